FILE: src/pbfa_pkg.sv
// Shared types and constants for the packed bit-field array.
`timescale 1ns / 1ps

package pbfa_pkg;

   localparam int MAX_ITEMS_DEF  = 4096;
   localparam int WORD_COUNT_DEF = 2048;

   localparam int WORD_W  = 64;
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 12;
   localparam int BPI_W   = 6;
   localparam int COUNT_W = 13;
   localparam int POS_W   = INDEX_W + BPI_W;
   localparam int OFF_W   = 6;
   localparam int CSR_DATA_W = 32;

   localparam logic [BPI_W-1:0]   BPI_RESET   = 6'd1;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;
   localparam logic [BPI_W-1:0]   BPI_MAX     = 6'd32;

   typedef enum logic {
      CSR_BITS_PER_ITEM = 1'b0,
      CSR_ITEM_COUNT    = 1'b1
   } csr_index_type;

   typedef enum logic {
      ACT_READ  = 1'b0,
      ACT_WRITE = 1'b1
   } action_type;

   typedef enum logic {
      STAT_DONE  = 1'b0,
      STAT_RANGE = 1'b1
   } status_type;

   typedef struct packed {
      logic                action;
      logic [INDEX_W-1:0]  item_index;
      logic [VALUE_W-1:0]  write_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  read_value;
      logic                status;
   } rsp_type;

   typedef struct packed {
      logic                sel_hi;
      logic [OFF_W-1:0]    off;
      logic [VALUE_W-1:0]  value;
      logic [VALUE_W-1:0]  mask;
      logic [WORD_W-1:0]   word;
   } unit_req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   wr_word;
      logic [VALUE_W-1:0]  rd_part;
   } unit_rsp_type;

endpackage

FILE: src/pbfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pbfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pbfa_field_unit.sv
// Shared shift/merge unit: inserts or extracts a field in one store word.
`timescale 1ns / 1ps

module pbfa_field_unit (
   input  pbfa_pkg::unit_req_type u_req,
   output pbfa_pkg::unit_rsp_type u_rsp
);

   localparam int SW = pbfa_pkg::WORD_W + pbfa_pkg::VALUE_W;

   logic [SW-1:0]              ins;
   logic [SW-1:0]              msk;
   logic [pbfa_pkg::WORD_W-1:0] ins_part;
   logic [pbfa_pkg::WORD_W-1:0] msk_part;
   logic [SW-1:0]              src;
   logic [SW-1:0]              rd_shift;

   always_comb begin
      ins = SW'(u_req.value) << u_req.off;
      msk = SW'(u_req.mask) << u_req.off;
      if (u_req.sel_hi) begin
         ins_part = pbfa_pkg::WORD_W'(ins[SW-1:pbfa_pkg::WORD_W]);
         msk_part = pbfa_pkg::WORD_W'(msk[SW-1:pbfa_pkg::WORD_W]);
         src      = {u_req.word[pbfa_pkg::VALUE_W-1:0], {pbfa_pkg::WORD_W{1'b0}}};
      end else begin
         ins_part = ins[pbfa_pkg::WORD_W-1:0];
         msk_part = msk[pbfa_pkg::WORD_W-1:0];
         src      = {{pbfa_pkg::VALUE_W{1'b0}}, u_req.word};
      end
      rd_shift      = src >> u_req.off;
      u_rsp.wr_word = (u_req.word & ~msk_part) | ins_part;
      u_rsp.rd_part = rd_shift[pbfa_pkg::VALUE_W-1:0];
   end

endmodule

FILE: src/packed_bit_field_array.sv
// Top level: packed bit-field array with sequencer, word store and field unit.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; exactly one response
// follows, shown on rsp_payload with rsp_strobe, which is high for one cycle;
// the payload holds until the next response. For an in-range request the
// index-times-width product is registered in ST_MUL, then the single-read-port
// word store is read once per word (in ST_RD, and in ST_LO for the high word
// when the field straddles two words) and the shared shift/merge unit processes
// one word per cycle (ST_LO, then ST_HI). Busy drops in the strobe cycle. An
// out-of-range request answers on the next cycle and busy stays low. After
// reset the store is cleared one word per cycle, every word of it, with busy
// high; configuration writes are taken at any time but belong in idle periods.
module packed_bit_field_array #(
   parameter int MAX_ITEMS  = pbfa_pkg::MAX_ITEMS_DEF,
   parameter int WORD_COUNT = pbfa_pkg::WORD_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  pbfa_pkg::req_type                   req_payload,
   output logic                                rsp_strobe,
   output pbfa_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  pbfa_pkg::csr_index_type             csr_index,
   input  logic [pbfa_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam logic [31:0] WordCountW = 32'(WORD_COUNT);
   localparam logic [31:0] MaxItemsW  = 32'(MAX_ITEMS);
   localparam logic [AW-1:0] LastWord = AW'(WORD_COUNT - 1);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_MUL, ST_RD, ST_LO, ST_HI
   } state_type;

   state_type                           state_ff, state_in;
   logic [AW-1:0]                       clr_ff, clr_in;
   logic [pbfa_pkg::BPI_W-1:0]          bpi_ff, bpi_in;
   logic [pbfa_pkg::COUNT_W-1:0]        cnt_ff, cnt_in;
   logic                                act_ff, act_in;
   logic [pbfa_pkg::INDEX_W-1:0]        idx_ff, idx_in;
   logic [pbfa_pkg::VALUE_W-1:0]        val_ff, val_in;
   logic [pbfa_pkg::VALUE_W-1:0]        mask_ff, mask_in;
   logic [pbfa_pkg::BPI_W-1:0]          w_ff, w_in;
   logic [pbfa_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic [pbfa_pkg::VALUE_W-1:0]        rd_ff, rd_in;
   logic                                rsp_strobe_ff, rsp_strobe_in;
   pbfa_pkg::rsp_type                   rsp_ff, rsp_in;

   logic [pbfa_pkg::BPI_W-1:0]          w_eff;
   logic                                in_range;
   logic [31:0]                         word_lo;
   logic [31:0]                         word_hi;
   logic                                lo_ok;
   logic                                hi_ok;
   logic [6:0]                          off_end;
   logic                                split;
   logic [pbfa_pkg::OFF_W-1:0]          off;

   logic                                ram_we;
   logic [AW-1:0]                       ram_waddr;
   logic [pbfa_pkg::WORD_W-1:0]         ram_wdata;
   logic [AW-1:0]                       ram_raddr;
   logic [pbfa_pkg::WORD_W-1:0]         ram_rdata;

   pbfa_pkg::unit_req_type              u_req;
   pbfa_pkg::unit_rsp_type              u_rsp;

   pbfa_ram #(
      .WIDTH (pbfa_pkg::WORD_W),
      .DEPTH (WORD_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   pbfa_field_unit u_unit (
      .u_req (u_req),
      .u_rsp (u_rsp)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      if (bpi_ff == '0) begin
         w_eff = pbfa_pkg::BPI_W'(1);
      end else if (bpi_ff > pbfa_pkg::BPI_MAX) begin
         w_eff = pbfa_pkg::BPI_MAX;
      end else begin
         w_eff = bpi_ff;
      end
      in_range = (32'(req_payload.item_index) < 32'(cnt_ff)) &&
                 (32'(req_payload.item_index) < MaxItemsW);

      off     = pos_ff[pbfa_pkg::OFF_W-1:0];
      word_lo = 32'(pos_ff[pbfa_pkg::POS_W-1:pbfa_pkg::OFF_W]);
      word_hi = word_lo + 32'd1;
      lo_ok   = word_lo < WordCountW;
      hi_ok   = word_hi < WordCountW;
      off_end = 7'(off) + 7'(w_ff);
      split   = off_end > 7'd64;

      u_req.sel_hi = (state_ff == ST_HI);
      u_req.off    = off;
      u_req.value  = val_ff;
      u_req.mask   = mask_ff;
      if (state_ff == ST_HI) begin
         u_req.word = hi_ok ? ram_rdata : '0;
      end else begin
         u_req.word = lo_ok ? ram_rdata : '0;
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = word_lo[AW-1:0];
      ram_wdata = u_rsp.wr_word;
      ram_raddr = word_lo[AW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         ST_LO: begin
            ram_we    = (act_ff == pbfa_pkg::ACT_WRITE) && lo_ok;
            ram_raddr = word_hi[AW-1:0];
         end
         ST_HI: begin
            ram_we    = (act_ff == pbfa_pkg::ACT_WRITE) && hi_ok;
            ram_waddr = word_hi[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      bpi_in        = bpi_ff;
      cnt_in        = cnt_ff;
      act_in        = act_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      mask_in       = mask_ff;
      w_in          = w_ff;
      pos_in        = pos_ff;
      rd_in         = rd_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (csr_valid) begin
         unique case (csr_index)
            pbfa_pkg::CSR_BITS_PER_ITEM: bpi_in = csr_wdata[pbfa_pkg::BPI_W-1:0];
            pbfa_pkg::CSR_ITEM_COUNT:    cnt_in = csr_wdata[pbfa_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LastWord) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (in_range) begin
                  act_in   = req_payload.action;
                  idx_in   = req_payload.item_index;
                  w_in     = w_eff;
                  mask_in  = ~({pbfa_pkg::VALUE_W{1'b1}} << w_eff);
                  val_in   = req_payload.write_value & ~({pbfa_pkg::VALUE_W{1'b1}} << w_eff);
                  state_in = ST_MUL;
               end else begin
                  rsp_strobe_in     = 1'b1;
                  rsp_in.read_value = '0;
                  rsp_in.status     = pbfa_pkg::STAT_RANGE;
               end
            end
         end
         ST_MUL: begin
            pos_in   = pbfa_pkg::POS_W'(idx_ff) * pbfa_pkg::POS_W'(w_ff);
            state_in = ST_RD;
         end
         ST_RD: begin
            state_in = ST_LO;
         end
         ST_LO: begin
            rd_in = u_rsp.rd_part;
            if (split) begin
               state_in = ST_HI;
            end else begin
               state_in          = ST_IDLE;
               rsp_strobe_in     = 1'b1;
               rsp_in.status     = pbfa_pkg::STAT_DONE;
               rsp_in.read_value = (act_ff == pbfa_pkg::ACT_WRITE) ? '0 :
                                   (u_rsp.rd_part & mask_ff);
            end
         end
         ST_HI: begin
            state_in          = ST_IDLE;
            rsp_strobe_in     = 1'b1;
            rsp_in.status     = pbfa_pkg::STAT_DONE;
            rsp_in.read_value = (act_ff == pbfa_pkg::ACT_WRITE) ? '0 :
                                ((rd_ff | u_rsp.rd_part) & mask_ff);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         bpi_ff        <= pbfa_pkg::BPI_RESET;
         cnt_ff        <= pbfa_pkg::COUNT_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         bpi_ff        <= bpi_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      act_ff  <= act_in;
      idx_ff  <= idx_in;
      val_ff  <= val_in;
      mask_ff <= mask_in;
      w_ff    <= w_in;
      pos_ff  <= pos_in;
      rd_ff   <= rd_in;
      rsp_ff  <= rsp_in;
   end

endmodule
